// ----- rtl/ipn2d_pkg.sv -----
// ----------------------------------------------------------------------------
// ipn2d_pkg - shared types and constants for 2D improved Perlin noise
// Command codes, field widths and parameter defaults used by the channel
// interfaces and the noise pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ipn2d_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 256;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned ENTRY_W = 8;
  localparam int unsigned NOISE_W = 18;

  typedef enum logic {
    CMD_EVAL = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_e;

endpackage

`default_nettype wire

// ----- rtl/ipn2d_intf.sv -----
// ----------------------------------------------------------------------------
// ipn2d_intf - valid/ready channels of the Perlin noise block
// Request channel carries commands and coordinates, response channel
// carries one noise sample per evaluate beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipn2d_req_if;
  import ipn2d_pkg::*;

  logic                      valid;
  logic                      ready;
  cmd_e                      command;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic [ENTRY_W-1:0]        entry_index;
  logic [ENTRY_W-1:0]        entry_value;

  modport source (
    output valid, command, x_coord, y_coord, entry_index, entry_value,
    input  ready
  );

  modport sink (
    input  valid, command, x_coord, y_coord, entry_index, entry_value,
    output ready
  );
endinterface

interface ipn2d_rsp_if;
  import ipn2d_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [NOISE_W-1:0] noise_value;

  modport source (
    output valid, noise_value,
    input  ready
  );

  modport sink (
    input  valid, noise_value,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/improved_perlin_noise_2d.sv -----
// ----------------------------------------------------------------------------
// improved_perlin_noise_2d - pipelined 2D improved Perlin noise
// Load beats fill the permutation table, evaluate beats return one
// saturated Q2.16 noise sample from signed fixed-point coordinates.
//
//   channel  dir  beat content                                    count
//   req_i    in   command, x_coord, y_coord, entry_index/value    1/clk if ready
//   rsp_o    out  noise_value                                     1/evaluate
//
// One beat enters per cycle while stage 1 can move; a sample passes through
// 9 register stages after its request beat is taken, set by the two dependent
// table lookups, the three-multiply fade chain and the two levels of interpolation.
// Reset clears only the stage valid bits; the table is undefined until loaded.
// Each stage moves when the stage after it has room, so bubbles close up and
// requests keep flowing while a finished sample waits on rsp_o, until all are full.
// TABLE_DEPTH must be a power of two; the block itself does not check it.
// ----------------------------------------------------------------------------
`default_nettype none

module improved_perlin_noise_2d #(
  parameter int unsigned TABLE_DEPTH = ipn2d_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned FRAC_BITS   = ipn2d_pkg::FRAC_BITS_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  ipn2d_req_if.sink   req_i,
  ipn2d_rsp_if.source rsp_o
);
  import ipn2d_pkg::*;

  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned NW = F + 2;   // dot products and lerp results
  localparam int unsigned DW = F + 3;   // differences of dot products
  localparam int unsigned PW = F + 4;   // fade polynomial
  localparam int unsigned MW = 2 * F + 4;
  localparam int unsigned SW = F + 11;  // scaled result before clamping
  localparam int unsigned NS = 9;

  localparam logic [PW-1:0] TEN_ONE = PW'(10 * (2 ** F));
  localparam logic signed [SW-1:0] SAT_HI = SW'((2 ** (NOISE_W - 1)) - 1);
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

  typedef enum logic [1:0] {
    GRAD_PP = 2'd0,
    GRAD_NP = 2'd1,
    GRAD_NN = 2'd2,
    GRAD_PN = 2'd3
  } grad_e;

  function automatic logic signed [NW-1:0] grad_dot(
    input logic [1:0]           h,
    input logic signed [NW-1:0] dx,
    input logic signed [NW-1:0] dy
  );
    unique case (grad_e'(h))
      GRAD_PP: grad_dot = dx + dy;
      GRAD_NP: grad_dot = dy - dx;
      GRAD_NN: grad_dot = -dx - dy;
      GRAD_PN: grad_dot = dx - dy;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stage control
  // --------------------------------------------------------------------------
  logic [NS:1] v_q, v_d, en;

  logic            s1_cmd_q, s2_cmd_q;
  logic [AW-1:0]   s1_waddr_q, s2_waddr_q;
  logic [7:0]      s1_wval_q, s2_wval_q;

  always_comb begin
    en[NS] = !v_q[NS] || rsp_o.ready;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_comb begin
    v_d    = v_q;
    v_d[1] = req_i.valid;
    v_d[2] = v_q[1];
    // loads are done once the last table copy is written
    v_d[3] = v_q[2] && (cmd_e'(s2_cmd_q) == CMD_EVAL);
    for (int k = 4; k <= NS; k++) begin
      v_d[k] = v_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (en[k]) v_q[k] <= v_d[k];
      end
    end
  end

  assign req_i.ready = en[1];

  // --------------------------------------------------------------------------
  // Stage 1: split coordinates into cell index and fraction
  // --------------------------------------------------------------------------
  logic signed [COORD_W-1:0] ixs, iys;
  logic [AW+7:0]             waddr_ext;
  logic [AW-1:0]             s1_cx_q, s1_cy_q, s1_cx_p1;
  logic [F-1:0]              s1_xf_q, s1_yf_q;

  assign ixs       = req_i.x_coord >>> F;
  assign iys       = req_i.y_coord >>> F;
  assign waddr_ext = {{AW{1'b0}}, req_i.entry_index};

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_cmd_q   <= req_i.command;
      s1_waddr_q <= waddr_ext[AW-1:0];
      s1_wval_q  <= req_i.entry_value;
      s1_cx_q    <= ixs[AW-1:0];
      s1_cy_q    <= iys[AW-1:0];
      s1_xf_q    <= req_i.x_coord[F-1:0];
      s1_yf_q    <= req_i.y_coord[F-1:0];
    end
  end

  assign s1_cx_p1 = s1_cx_q + AW'(1);

  // Table copy A: first-level lookups. A load writes it as it leaves stage 1,
  // in order with the evaluate beats around it.
  logic [7:0] perm_a_q [TABLE_DEPTH];
  logic [7:0] s2_hx0_q, s2_hx1_q;
  logic       wr_a;

  assign wr_a = v_q[1] && (cmd_e'(s1_cmd_q) == CMD_LOAD) && en[2];

  always_ff @(posedge clk_i) begin
    if (wr_a) perm_a_q[s1_waddr_q] <= s1_wval_q;
    if (en[2]) begin
      s2_hx0_q <= perm_a_q[s1_cx_q];
      s2_hx1_q <= perm_a_q[s1_cx_p1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: square the fractions
  // --------------------------------------------------------------------------
  logic [AW-1:0]  s2_cy_q;
  logic [F-1:0]   s2_xf_q, s2_yf_q;
  logic [2*F-1:0] s2_sqx_q, s2_sqy_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_cmd_q   <= s1_cmd_q;
      s2_waddr_q <= s1_waddr_q;
      s2_wval_q  <= s1_wval_q;
      s2_cy_q    <= s1_cy_q;
      s2_xf_q    <= s1_xf_q;
      s2_yf_q    <= s1_yf_q;
      s2_sqx_q   <= s1_xf_q * s1_xf_q;
      s2_sqy_q   <= s1_yf_q * s1_yf_q;
    end
  end

  // second-level hash addresses, wrapped to the table depth
  logic [AW+7:0] sum_l, sum_r;
  logic [AW-1:0] a_bl, a_tl, a_br, a_tr;

  assign sum_l = {{AW{1'b0}}, s2_hx0_q} + {8'h00, s2_cy_q};
  assign sum_r = {{AW{1'b0}}, s2_hx1_q} + {8'h00, s2_cy_q};
  assign a_bl  = sum_l[AW-1:0];
  assign a_tl  = a_bl + AW'(1);
  assign a_br  = sum_r[AW-1:0];
  assign a_tr  = a_br + AW'(1);

  // Table copies B and C: second-level lookups, written as a load leaves stage 2
  logic [7:0] perm_b_q [TABLE_DEPTH];
  logic [7:0] perm_c_q [TABLE_DEPTH];
  logic [7:0] s3_hbl_q, s3_htl_q, s3_hbr_q, s3_htr_q;
  logic       wr_bc;

  assign wr_bc = v_q[2] && (cmd_e'(s2_cmd_q) == CMD_LOAD) && en[3];

  always_ff @(posedge clk_i) begin
    if (wr_bc) perm_b_q[s2_waddr_q] <= s2_wval_q;
    if (en[3]) begin
      s3_hbl_q <= perm_b_q[a_bl];
      s3_htl_q <= perm_b_q[a_tl];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_bc) perm_c_q[s2_waddr_q] <= s2_wval_q;
    if (en[3]) begin
      s3_hbr_q <= perm_c_q[a_br];
      s3_htr_q <= perm_c_q[a_tr];
    end
  end

  // fade: t3 = (t2 * t) >> F, p = 10*one - 15t + (6 t^2 >> F)
  logic [F-1:0]     t2x, t2y;
  logic [2*F-1:0]   t3x_full, t3y_full;
  logic [2*F+2:0]   six_sqx, six_sqy;
  logic [PW-1:0]    fif_tx, fif_ty, px, py;

  assign t2x      = s2_sqx_q[2*F-1:F];
  assign t2y      = s2_sqy_q[2*F-1:F];
  assign t3x_full = t2x * s2_xf_q;
  assign t3y_full = t2y * s2_yf_q;
  assign six_sqx  = ({3'b000, s2_sqx_q} << 2) + ({3'b000, s2_sqx_q} << 1);
  assign six_sqy  = ({3'b000, s2_sqy_q} << 2) + ({3'b000, s2_sqy_q} << 1);
  assign fif_tx   = ({4'h0, s2_xf_q} << 4) - {4'h0, s2_xf_q};
  assign fif_ty   = ({4'h0, s2_yf_q} << 4) - {4'h0, s2_yf_q};
  assign px       = TEN_ONE + {1'b0, six_sqx[2*F+2:F]} - fif_tx;
  assign py       = TEN_ONE + {1'b0, six_sqy[2*F+2:F]} - fif_ty;

  // --------------------------------------------------------------------------
  // Stage 3: gradient dot products, last fade multiply
  // --------------------------------------------------------------------------
  logic [F-1:0]  s3_xf_q, s3_yf_q, s3_t3x_q, s3_t3y_q;
  logic [PW-1:0] s3_px_q, s3_py_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_xf_q  <= s2_xf_q;
      s3_yf_q  <= s2_yf_q;
      s3_t3x_q <= t3x_full[2*F-1:F];
      s3_t3y_q <= t3y_full[2*F-1:F];
      s3_px_q  <= px;
      s3_py_q  <= py;
    end
  end

  logic signed [NW-1:0] dx0, dx1, dy0, dy1;
  logic [2*F+3:0]       fade_x, fade_y;

  // x - 1 in NW bits is the fraction under a 2'b11 prefix
  assign dx0    = $signed({2'b00, s3_xf_q});
  assign dx1    = $signed({2'b11, s3_xf_q});
  assign dy0    = $signed({2'b00, s3_yf_q});
  assign dy1    = $signed({2'b11, s3_yf_q});
  assign fade_x = s3_t3x_q * s3_px_q;
  assign fade_y = s3_t3y_q * s3_py_q;

  logic signed [NW-1:0] s4_dbl_q, s4_dtl_q, s4_dbr_q, s4_dtr_q;
  logic [F-1:0]         s4_u_q, s4_v_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_dbl_q <= grad_dot(s3_hbl_q[1:0], dx0, dy0);
      s4_dtl_q <= grad_dot(s3_htl_q[1:0], dx0, dy1);
      s4_dbr_q <= grad_dot(s3_hbr_q[1:0], dx1, dy0);
      s4_dtr_q <= grad_dot(s3_htr_q[1:0], dx1, dy1);
      s4_u_q   <= fade_x[2*F-1:F];
      s4_v_q   <= fade_y[2*F-1:F];
    end
  end

  // --------------------------------------------------------------------------
  // Stages 5-8: bilinear interpolation
  // --------------------------------------------------------------------------
  logic signed [NW-1:0] s5_dbl_q, s5_dbr_q;
  logic signed [DW-1:0] s5_e0_q, s5_e1_q;
  logic [F-1:0]         s5_u_q, s5_v_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_dbl_q <= s4_dbl_q;
      s5_dbr_q <= s4_dbr_q;
      s5_e0_q  <= DW'(s4_dtl_q) - DW'(s4_dbl_q);
      s5_e1_q  <= DW'(s4_dtr_q) - DW'(s4_dbr_q);
      s5_u_q   <= s4_u_q;
      s5_v_q   <= s4_v_q;
    end
  end

  logic signed [NW-1:0] s6_dbl_q, s6_dbr_q;
  logic signed [MW-1:0] s6_m0_q, s6_m1_q;
  logic [F-1:0]         s6_u_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s6_dbl_q <= s5_dbl_q;
      s6_dbr_q <= s5_dbr_q;
      s6_m0_q  <= s5_e0_q * $signed({1'b0, s5_v_q});
      s6_m1_q  <= s5_e1_q * $signed({1'b0, s5_v_q});
      s6_u_q   <= s5_u_q;
    end
  end

  // lerp results lie between their end points, so NW bits hold them
  logic signed [NW-1:0] l0, l1;

  assign l0 = s6_dbl_q + $signed(s6_m0_q[F+NW-1:F]);
  assign l1 = s6_dbr_q + $signed(s6_m1_q[F+NW-1:F]);

  logic signed [NW-1:0] s7_l0_q;
  logic signed [DW-1:0] s7_f_q;
  logic [F-1:0]         s7_u_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s7_l0_q <= l0;
      s7_f_q  <= DW'(l1) - DW'(l0);
      s7_u_q  <= s6_u_q;
    end
  end

  logic signed [NW-1:0] s8_l0_q;
  logic signed [MW-1:0] s8_mm_q;

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      s8_l0_q <= s7_l0_q;
      s8_mm_q <= s7_f_q * $signed({1'b0, s7_u_q});
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: final lerp, move to 16 fraction bits, clamp
  // --------------------------------------------------------------------------
  logic signed [NW-1:0]      noise;
  logic signed [SW-1:0]      wide, scaled;
  logic signed [NOISE_W-1:0] sat;
  logic signed [NOISE_W-1:0] s9_noise_q;

  assign noise  = s8_l0_q + $signed(s8_mm_q[F+NW-1:F]);
  assign wide   = {noise[NW-1], noise, 8'h00};
  assign scaled = wide >>> (F - 8);

  always_comb begin
    priority if (scaled > SAT_HI) begin
      sat = SAT_HI[NOISE_W-1:0];
    end else if (scaled < SAT_LO) begin
      sat = SAT_LO[NOISE_W-1:0];
    end else begin
      sat = scaled[NOISE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[9]) s9_noise_q <= sat;
  end

  assign rsp_o.valid       = v_q[NS];
  assign rsp_o.noise_value = s9_noise_q;

`ifndef SYNTH
  // an empty output register means every stage can move
  a_ready_when_out_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !v_q[NS] |-> req_i.ready
  ) else $error("request stalled with empty output register");

  // a full pipeline under back-pressure takes no request
  a_full_blocks: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (v_q == {NS{1'b1}} && !rsp_o.ready) |-> !req_i.ready
  ) else $error("request taken into a full stalled pipeline");

  // the sample behind a delivered one moves up in the same edge
  a_refill: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.ready && v_q[NS-1]) |=> rsp_o.valid
  ) else $error("queued sample lost after output beat");
`endif

endmodule

`default_nettype wire
